// File: sv/scfp_pkg.sv
// Shared types and constants for the serial command frame parser.
// No dependencies; every other module of the block imports this package.
package scfp_pkg;

    // Default number of payload bytes that are passed on per frame.
    localparam int unsigned PAYLOAD_CAPACITY_DEF = 64;

    // Register port widths: three 32-bit registers at byte addresses 0, 4 and 8.
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_START_MARKER  = 2'd0,
        REG_STOP_MARKER   = 2'd1,
        REG_COMMAND_LIMIT = 2'd2
    } reg_idx_t;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Error causes reported in a status result.
    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_BAD_CMD  = 2'd1,
        CAUSE_OVERFLOW = 2'd2,
        CAUSE_BAD_STOP = 2'd3
    } cause_t;

    // Configuration as seen by the parser.
    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] stop_marker;
        logic [8:0] command_limit;
    } cfg_t;

    // One result item plus its valid flag.
    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [7:0]  payload_byte;
        logic [5:0]  payload_index;
        logic [7:0]  frame_command;
        logic [7:0]  node_id;
        logic [15:0] ext_id;
        logic [7:0]  frame_length;
        logic        frame_ok;
        cause_t      error_cause;
    } result_t;

endpackage

// File: sv/scfp_cfg_regs.sv
// Configuration register file of the frame parser, behind an APB-style port.
// Depends on scfp_pkg for the register indexes and the cfg_t struct.
module scfp_cfg_regs
    import scfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output cfg_t              cfg
);

    logic [7:0] start_marker_reg;
    logic [7:0] stop_marker_reg;
    logic [8:0] command_limit_reg;
    logic       wr_en;
    reg_idx_t   reg_idx;

    // A write transfer completes in the access phase; pready is always high.
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg  <= 8'd0;
            stop_marker_reg   <= 8'd0;
            command_limit_reg <= 9'd256;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_START_MARKER:  start_marker_reg  <= pwdata[7:0];
                REG_STOP_MARKER:   stop_marker_reg   <= pwdata[7:0];
                REG_COMMAND_LIMIT: command_limit_reg <= pwdata[8:0];
                default:           ;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_START_MARKER:  prdata = {24'd0, start_marker_reg};
            REG_STOP_MARKER:   prdata = {24'd0, stop_marker_reg};
            REG_COMMAND_LIMIT: prdata = {23'd0, command_limit_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.start_marker  = start_marker_reg;
    assign cfg.stop_marker   = stop_marker_reg;
    assign cfg.command_limit = command_limit_reg;

endmodule

// File: sv/scfp_in_stage.sv
// Input register of the frame parser: holds one received byte until the parser takes it.
// Depends on scfp_pkg only through the common import convention.
module scfp_in_stage
    import scfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    input  logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       full,
    output logic [7:0] byte_q
);

    logic       full_reg;
    logic       full_next;
    logic [7:0] byte_reg;
    logic       accept;

    assign accept = rx_valid && !rx_stall;

    // The register fills on an accepted transfer and empties when the parser takes it.
    always_comb
    begin
        full_next = full_reg;
        if (accept)
        begin
            full_next = 1'b1;
        end
        else if (advance)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // Payload register, loaded on every accepted transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign full   = full_reg;
    assign byte_q = byte_reg;

endmodule

// File: sv/scfp_parse.sv
// Frame state machine: decodes one byte per cycle while advance is high and forms the result for it.
// Depends on scfp_pkg for cfg_t, result_t, the cause codes and the result kinds.
module scfp_parse
    import scfp_pkg::*;
#(
    parameter int unsigned PAYLOAD_CAPACITY = PAYLOAD_CAPACITY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       advance,
    input  logic [7:0] in_byte,
    output result_t    res
);

    localparam logic [7:0] CAPACITY = 8'(PAYLOAD_CAPACITY);

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_CMD     = 8'b0000_0010,
        PH_NODE    = 8'b0000_0100,
        PH_EXT_HI  = 8'b0000_1000,
        PH_EXT_LO  = 8'b0001_0000,
        PH_LEN     = 8'b0010_0000,
        PH_PAYLOAD = 8'b0100_0000,
        PH_STOP    = 8'b1000_0000
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic [7:0]  command_reg,  command_next;
    logic [7:0]  node_id_reg,  node_id_next;
    logic [15:0] ext_id_reg,   ext_id_next;
    logic [7:0]  length_reg,   length_next;
    logic [7:0]  count_reg,    count_next;
    logic        overflow_reg, overflow_next;
    logic [7:0]  count_inc;
    cause_t      stop_cause;

    assign count_inc = count_reg + 8'd1;

    // Overflow takes precedence over a wrong stop byte.
    always_comb
    begin
        if (overflow_reg)
        begin
            stop_cause = CAUSE_OVERFLOW;
        end
        else if (in_byte != cfg.stop_marker)
        begin
            stop_cause = CAUSE_BAD_STOP;
        end
        else
        begin
            stop_cause = CAUSE_NONE;
        end
    end

    // Next state and the result of the byte that advances this cycle.
    always_comb
    begin
        phase_next    = phase_reg;
        command_next  = command_reg;
        node_id_next  = node_id_reg;
        ext_id_next   = ext_id_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        res           = '0;
        if (advance)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (in_byte == cfg.start_marker)
                    begin
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    command_next  = in_byte;
                    overflow_next = 1'b0;
                    if ({1'b0, in_byte} < cfg.command_limit)
                    begin
                        phase_next = PH_NODE;
                    end
                    else
                    begin
                        // A rejected command ends the frame at once.
                        res.valid         = 1'b1;
                        res.kind          = KIND_STATUS;
                        res.frame_command = in_byte;
                        res.error_cause   = CAUSE_BAD_CMD;
                        phase_next        = PH_IDLE;
                    end
                end
                PH_NODE:
                begin
                    node_id_next = in_byte;
                    phase_next   = PH_EXT_HI;
                end
                PH_EXT_HI:
                begin
                    ext_id_next = {in_byte, 8'd0};
                    phase_next  = PH_EXT_LO;
                end
                PH_EXT_LO:
                begin
                    ext_id_next = {ext_id_reg[15:8], in_byte};
                    phase_next  = PH_LEN;
                end
                PH_LEN:
                begin
                    length_next = in_byte;
                    count_next  = 8'd0;
                    phase_next  = (in_byte != 8'd0) ? PH_PAYLOAD : PH_STOP;
                end
                PH_PAYLOAD:
                begin
                    if (count_reg < CAPACITY)
                    begin
                        res.valid         = 1'b1;
                        res.kind          = KIND_PAYLOAD;
                        res.payload_byte  = in_byte;
                        res.payload_index = count_reg[5:0];
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    count_next = count_inc;
                    if (count_inc == length_reg)
                    begin
                        phase_next = PH_STOP;
                    end
                end
                PH_STOP:
                begin
                    res.valid         = 1'b1;
                    res.kind          = KIND_STATUS;
                    res.frame_command = command_reg;
                    res.node_id       = node_id_reg;
                    res.ext_id        = ext_id_reg;
                    res.frame_length  = length_reg;
                    res.frame_ok      = (stop_cause == CAUSE_NONE);
                    res.error_cause   = stop_cause;
                    phase_next        = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            command_reg  <= 8'd0;
            node_id_reg  <= 8'd0;
            ext_id_reg   <= 16'd0;
            length_reg   <= 8'd0;
            count_reg    <= 8'd0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            command_reg  <= command_next;
            node_id_reg  <= node_id_next;
            ext_id_reg   <= ext_id_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // The payload phase always has bytes left to read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (count_reg < length_reg))
        else $error("payload phase entered with no bytes left");

    // An overflow at the stop byte means more bytes arrived than the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_STOP && overflow_reg) |-> (count_reg > CAPACITY))
        else $error("overflow flagged without exceeding capacity");

    // A command byte either opens the header or ends the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_CMD) |=> (phase_reg == PH_NODE || phase_reg == PH_IDLE))
        else $error("unexpected phase after command byte");

    // A status result is emitted only for a command or stop byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.kind == KIND_STATUS) |-> (phase_reg == PH_CMD || phase_reg == PH_STOP))
        else $error("status result outside command or stop phase");

endmodule

// File: sv/scfp_out_stage.sv
// Result register of the frame parser, holding one result until its transfer completes.
// Depends on scfp_pkg for the result_t struct.
module scfp_out_stage
    import scfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  result_t res,
    input  logic    res_stall,
    output logic    full,
    output result_t data
);

    logic    full_reg;
    logic    full_next;
    result_t data_reg;

    // Load on a new result, empty when the held result is taken.
    always_comb
    begin
        full_next = full_reg;
        if (res.valid)
        begin
            full_next = 1'b1;
        end
        else if (full_reg && !res_stall)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            data_reg <= res;
        end
    end

    assign full = full_reg;
    assign data = data_reg;

endmodule

// File: sv/serial_command_frame_parser.sv
// Serial command frame parser: one received byte in, at most one result out per byte.
// A byte passes through the input register, is decoded combinationally, and its result is
// held in the result register until its own transfer completes.
// The parser takes one byte per cycle while the result register is free or being drained.
// A held result stalls the input only while the output side is stalled.
// Reset (rst_n, asynchronous, active low) empties both registers, returns the parser to
// waiting for a start byte and sets the markers to 0 and the command limit to 256.
module serial_command_frame_parser
    import scfp_pkg::*;
#(
    parameter int unsigned PAYLOAD_CAPACITY = PAYLOAD_CAPACITY_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    input  logic              res_stall,
    output logic              kind,
    output logic [7:0]        payload_byte,
    output logic [5:0]        payload_index,
    output logic [7:0]        frame_command,
    output logic [7:0]        node_id,
    output logic [15:0]       ext_id,
    output logic [7:0]        frame_length,
    output logic              frame_ok,
    output logic [1:0]        error_cause
);

    cfg_t       cfg;
    logic       in_full;
    logic [7:0] in_byte;
    logic       out_full;
    logic       advance;
    result_t    res;
    result_t    out_data;

    assign pready = 1'b1;

    scfp_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // The held byte moves on whenever the result register is free or being drained.
    assign advance  = in_full && (!out_full || !res_stall);
    assign rx_stall = in_full && !advance;

    scfp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .full     (in_full),
        .byte_q   (in_byte)
    );

    scfp_parse #(
        .PAYLOAD_CAPACITY (PAYLOAD_CAPACITY)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .in_byte (in_byte),
        .res     (res)
    );

    scfp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_stall (res_stall),
        .full      (out_full),
        .data      (out_data)
    );

    // Result fields.
    assign res_valid     = out_full;
    assign kind          = out_data.kind;
    assign payload_byte  = out_data.payload_byte;
    assign payload_index = out_data.payload_index;
    assign frame_command = out_data.frame_command;
    assign node_id       = out_data.node_id;
    assign ext_id        = out_data.ext_id;
    assign frame_length  = out_data.frame_length;
    assign frame_ok      = out_data.frame_ok;
    assign error_cause   = out_data.error_cause;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for serial_command_frame_parser: a byte-level frame predictor,
// random idling on both sides, back-pressure and overflow tests. Depends on scfp_pkg.
`timescale 1ns / 100ps

module tb_top;
    import scfp_pkg::*;

    localparam int unsigned CAPACITY      = PAYLOAD_CAPACITY_DEF;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned LONG_HOLD     = 60;
    localparam int unsigned RANDOM_ITEMS  = 160;
    localparam int unsigned WHOLE_FRAME   = 1000;

    // Frame position of the byte that the predictor takes next.
    typedef enum logic [2:0] {
        WAIT_START,
        GET_CMD,
        GET_NODE,
        GET_EID_HI,
        GET_EID_LO,
        GET_LEN,
        GET_PAYLOAD,
        GET_STOP
    } frame_pos_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              rx_valid;
    logic              rx_stall;
    logic [7:0]        rx_byte;
    logic              res_valid;
    logic              res_stall;
    logic              kind;
    logic [7:0]        payload_byte;
    logic [5:0]        payload_index;
    logic [7:0]        frame_command;
    logic [7:0]        node_id;
    logic [15:0]       ext_id;
    logic [7:0]        frame_length;
    logic              frame_ok;
    logic [1:0]        error_cause;

    // Predictor copy of the registers and the frame state.
    logic [7:0]  cfg_start;
    logic [7:0]  cfg_stop;
    logic [8:0]  cfg_limit;
    frame_pos_t  pos;
    logic [7:0]  held_cmd;
    logic [7:0]  held_node;
    logic [15:0] held_eid;
    logic [7:0]  held_len;
    logic [7:0]  pay_cnt;
    logic        overflowed;

    // Results still owed by the parser, oldest first.
    result_t     frame_results_q[$];
    result_t     want;
    result_t     seen;
    int unsigned mismatches;

    // Idling controls shared with the test tasks.
    bit          rx_idle_on;
    bit          res_idle_on;
    int unsigned sink_hold_req;

    serial_command_frame_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .rx_valid      (rx_valid),
        .rx_stall      (rx_stall),
        .rx_byte       (rx_byte),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .frame_command (frame_command),
        .node_id       (node_id),
        .ext_id        (ext_id),
        .frame_length  (frame_length),
        .frame_ok      (frame_ok),
        .error_cause   (error_cause)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #5_000_000;
        $display("FAIL serial_command_frame_parser");
        $finish;
    end

    function automatic string fmt_result(input result_t r);
        return $sformatf({"kind=%0d byte=%02h idx=%0d cmd=%02h node=%02h eid=%04h",
                          " len=%0d ok=%0d cause=%0d"},
                         r.kind, r.payload_byte, r.payload_index, r.frame_command, r.node_id,
                         r.ext_id, r.frame_length, r.frame_ok, r.error_cause);
    endfunction

    // Queue a status result for the end of a frame or a rejected command.
    task automatic expect_status(input logic [7:0] cmd, input logic [7:0] node,
                                 input logic [15:0] eid, input logic [7:0] len, input cause_t why);
        result_t r;
        r               = '0;
        r.valid         = 1'b1;
        r.kind          = KIND_STATUS;
        r.frame_command = cmd;
        r.node_id       = node;
        r.ext_id        = eid;
        r.frame_length  = len;
        r.frame_ok      = (why == CAUSE_NONE);
        r.error_cause   = why;
        frame_results_q.push_back(r);
    endtask

    // Advance the frame predictor by one accepted byte.
    task automatic parse_byte(input logic [7:0] b);
        result_t r;
        case (pos)
            WAIT_START:
            begin
                if (b == cfg_start)
                    pos = GET_CMD;
            end
            GET_CMD:
            begin
                held_cmd   = b;
                overflowed = 1'b0;
                if ({1'b0, b} < cfg_limit)
                    pos = GET_NODE;
                else
                begin
                    expect_status(b, 8'h00, 16'h0000, 8'h00, CAUSE_BAD_CMD);
                    pos = WAIT_START;
                end
            end
            GET_NODE:
            begin
                held_node = b;
                pos       = GET_EID_HI;
            end
            GET_EID_HI:
            begin
                held_eid = {b, 8'h00};
                pos      = GET_EID_LO;
            end
            GET_EID_LO:
            begin
                held_eid[7:0] = b;
                pos           = GET_LEN;
            end
            GET_LEN:
            begin
                held_len = b;
                pay_cnt  = 8'd0;
                pos      = (b != 8'd0) ? GET_PAYLOAD : GET_STOP;
            end
            GET_PAYLOAD:
            begin
                if (pay_cnt < CAPACITY)
                begin
                    r               = '0;
                    r.valid         = 1'b1;
                    r.kind          = KIND_PAYLOAD;
                    r.payload_byte  = b;
                    r.payload_index = pay_cnt[5:0];
                    frame_results_q.push_back(r);
                end
                else
                    overflowed = 1'b1;
                pay_cnt = pay_cnt + 8'd1;
                if (pay_cnt == held_len)
                    pos = GET_STOP;
            end
            default:
            begin
                if (overflowed)
                    expect_status(held_cmd, held_node, held_eid, held_len, CAUSE_OVERFLOW);
                else if (b != cfg_stop)
                    expect_status(held_cmd, held_node, held_eid, held_len, CAUSE_BAD_STOP);
                else
                    expect_status(held_cmd, held_node, held_eid, held_len, CAUSE_NONE);
                pos = WAIT_START;
            end
        endcase
    endtask

    // Offer one byte, after a random gap if rx idling is on, and wait for its transfer.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = rx_idle_on ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (rx_stall);
        parse_byte(b);
    endtask

    // Send a frame with random payload; only the first upto bytes go out.
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] node,
                              input logic [15:0] eid, input logic [7:0] len,
                              input logic [7:0] stop, input int unsigned upto);
        logic [7:0] b;
        for (int i = 0; i < 7 + len && i < upto; i++)
        begin
            case (i)
                0:       b = cfg_start;
                1:       b = cmd;
                2:       b = node;
                3:       b = eid[15:8];
                4:       b = eid[7:0];
                5:       b = len;
                default: b = (i < 6 + len) ? 8'($urandom) : stop;
            endcase
            send_byte(b);
        end
    endtask

    // Stop offering bytes and wait until every owed result has arrived.
    task automatic drain_results();
        @(negedge clk);
        rx_valid <= 1'b0;
        while (frame_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write over the configuration port, done only with the parser idle.
    task automatic write_reg(input reg_idx_t idx, input logic [8:0] val);
        logic [DATA_W-1:0] word;
        drain_results();
        word = $urandom();
        if (idx == REG_COMMAND_LIMIT)
            word[8:0] = val;
        else
            word[7:0] = val[7:0];
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_MARKER: cfg_start = val[7:0];
            REG_STOP_MARKER:  cfg_stop  = val[7:0];
            default:          cfg_limit = val;
        endcase
    endtask

    task automatic set_config(input logic [7:0] start, input logic [7:0] stop,
                              input logic [8:0] limit);
        write_reg(REG_START_MARKER, {1'b0, start});
        write_reg(REG_STOP_MARKER, {1'b0, stop});
        write_reg(REG_COMMAND_LIMIT, limit);
    endtask

    // Reset configuration: start and stop are 0, every command is accepted.
    task automatic test_reset_config();
        send_byte(8'h37);
        send_frame(8'hFF, 8'hFF, 16'hFFFF, 8'd0, 8'h00, WHOLE_FRAME);
        send_frame(8'h00, 8'h00, 16'h0000, 8'd1, 8'h00, WHOLE_FRAME);
    endtask

    // Rejected command, start marker taken as a field, and a bad stop byte.
    task automatic test_markers_and_commands();
        set_config(8'hFF, 8'hFF, 9'h080);
        send_frame(8'h80, 8'h00, 16'h0000, 8'd0, 8'hFF, WHOLE_FRAME);
        send_frame(8'h7F, 8'hFF, 16'hFF00, 8'd2, 8'h00, WHOLE_FRAME);
        send_frame(8'h00, 8'h12, 16'h00FF, 8'd0, 8'hFF, WHOLE_FRAME);
    endtask

    // Command limit at 0, 1 and above 256.
    task automatic test_command_limits();
        set_config(8'h00, 8'hFF, 9'd0);
        send_frame(8'h00, 8'h01, 16'h0102, 8'd1, 8'hFF, WHOLE_FRAME);
        write_reg(REG_COMMAND_LIMIT, 9'd1);
        send_frame(8'h00, 8'h55, 16'hAAAA, 8'd0, 8'hFF, WHOLE_FRAME);
        send_frame(8'h01, 8'h55, 16'h5555, 8'd0, 8'hFF, WHOLE_FRAME);
        write_reg(REG_COMMAND_LIMIT, 9'h1FF);
        send_frame(8'hFF, 8'hAA, 16'h5555, 8'd1, 8'hFF, WHOLE_FRAME);
    endtask

    // Long receiver hold-off while long frames overflow or exactly fill the payload capacity.
    task automatic test_backpressure_overflow();
        set_config(8'h5A, 8'hA5, 9'd256);
        rx_idle_on    = 1'b0;
        res_idle_on   = 1'b0;
        sink_hold_req = LONG_HOLD;
        send_frame(8'h11, 8'h22, 16'h3344, 8'd70, 8'hA5, WHOLE_FRAME);
        drain_results();
        send_frame(8'h66, 8'h77, 16'h8899, 8'd66, 8'h00, WHOLE_FRAME);
        send_frame(8'hCC, 8'hDD, 16'hEEFF, CAPACITY[7:0], 8'hA5, WHOLE_FRAME);
        rx_idle_on  = 1'b1;
        res_idle_on = 1'b1;
    endtask

    // Random frames under several random configurations, with noise and cut frames.
    task automatic test_random_frames();
        int unsigned sent;
        int unsigned len;
        int unsigned upto;
        logic [8:0]  cmd_top;
        logic [7:0]  cmd;
        logic [7:0]  stop;
        logic [7:0]  noise;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_config(8'($urandom), 8'($urandom),
                       ($urandom_range(0, 4) == 0) ? 9'($urandom_range(257, 511))
                                                   : 9'($urandom_range(0, 256)));
            rx_idle_on  = (ph != 0);
            res_idle_on = (ph != 0);
            sent        = 0;
            while (sent < RANDOM_ITEMS / 4)
            begin
                repeat ($urandom_range(0, 2))
                begin
                    do
                        noise = 8'($urandom);
                    while (noise == cfg_start);
                    send_byte(noise);
                    sent++;
                end
                len     = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 90)
                                                       : $urandom_range(0, 8);
                cmd_top = (cfg_limit > 9'd256) ? 9'd256 : cfg_limit;
                if (cmd_top != 0 && $urandom_range(0, 9) != 0)
                    cmd = 8'($urandom_range(0, cmd_top - 1));
                else
                    cmd = 8'($urandom);
                stop = ($urandom_range(0, 7) != 0) ? cfg_stop : 8'($urandom);
                upto = ($urandom_range(0, 14) == 0) ? $urandom_range(1, 6 + len) : 7 + len;
                send_frame(cmd, 8'($urandom), 16'($urandom), 8'(len), stop, upto);
                sent += (upto < 7 + len) ? upto : 7 + len;
            end
        end
    endtask

    // Result receiver: random stall before each result if idling is on, long hold-off on request.
    initial
    begin : result_sink
        int unsigned n;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold_req != 0)
            begin
                n             = sink_hold_req;
                sink_hold_req = 0;
            end
            else
                n = res_idle_on ? $urandom_range(0, 6) : 0;
            @(negedge clk);
            if (n != 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(res_valid && !res_stall));
        end
    end

    // Compare every result transfer with the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            seen               = '0;
            seen.valid         = 1'b1;
            seen.kind          = kind;
            seen.payload_byte  = payload_byte;
            seen.payload_index = payload_index;
            seen.frame_command = frame_command;
            seen.node_id       = node_id;
            seen.ext_id        = ext_id;
            seen.frame_length  = frame_length;
            seen.frame_ok      = frame_ok;
            seen.error_cause   = cause_t'(error_cause);
            if (frame_results_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t: %s", $realtime, fmt_result(seen));
            end
            else
            begin
                want = frame_results_q.pop_front();
                if (want.kind !== seen.kind || want.payload_byte !== seen.payload_byte ||
                    want.payload_index !== seen.payload_index ||
                    want.frame_command !== seen.frame_command ||
                    want.node_id !== seen.node_id || want.ext_id !== seen.ext_id ||
                    want.frame_length !== seen.frame_length ||
                    want.frame_ok !== seen.frame_ok || want.error_cause !== seen.error_cause)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", fmt_result(want));
                        $display("  actual   %s", fmt_result(seen));
                    end
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rx_valid      = 1'b0;
        rx_byte       = 8'h00;
        mismatches    = 0;
        rx_idle_on    = 1'b1;
        res_idle_on   = 1'b1;
        sink_hold_req = 0;
        cfg_start     = 8'h00;
        cfg_stop      = 8'h00;
        cfg_limit     = 9'd256;
        pos           = WAIT_START;
        held_cmd      = 8'h00;
        held_node     = 8'h00;
        held_eid      = 16'h0000;
        held_len      = 8'h00;
        pay_cnt       = 8'h00;
        overflowed    = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_config();
        test_markers_and_commands();
        test_command_limits();
        test_backpressure_overflow();
        test_random_frames();

        drain_results();
        if (mismatches == 0)
            $display("PASS serial_command_frame_parser");
        else
            $display("FAIL serial_command_frame_parser");
        $finish;
    end

endmodule

// File: filelist.f
sv/scfp_pkg.sv
sv/scfp_cfg_regs.sv
sv/scfp_in_stage.sv
sv/scfp_parse.sv
sv/scfp_out_stage.sv
sv/serial_command_frame_parser.sv
tb/sv/tb_top.sv
